// ===== sv/eip_pkg.sv =====
// ----------------------------------------------------------------------------
// eip_pkg: shared types and constants of the entity ID pool
// Request and response payloads, status codes, controller states and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package eip_pkg;

    localparam int NUM_IDS_DEF = 256;
    localparam int ID_W        = 16;
    localparam int GIVEN_W     = 8;

    typedef enum logic [0:0] {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NONE         = 2'd1,
        ST_INVALID      = 2'd2,
        ST_ALREADY_FREE = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd            command;
        logic [ID_W-1:0] entity_id;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [GIVEN_W-1:0] given_id;
    } t_rsp;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EVAL,
        S_SWAP,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic init;     // clearing pass write
        logic accept;   // latch request, launch map reads
        logic eval;     // check read data, first swap write
        logic swap2;    // second swap write
        logic rsp_load; // move result into the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic init_done;
        logic needs_swap;
        logic rsp_room;
    } t_dp_stat;

endpackage

// ===== sv/eip_if.sv =====
// ----------------------------------------------------------------------------
// eip_if: valid/ready channels of the entity ID pool
// Request channel and response channel, each with source and sink modports.
// ----------------------------------------------------------------------------
interface eip_req_if;
    logic          valid;
    logic          ready;
    eip_pkg::t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface eip_rsp_if;
    logic          valid;
    logic          ready;
    eip_pkg::t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/eip_ctrl.sv =====
// ----------------------------------------------------------------------------
// eip_ctrl: sequencing controller of the entity ID pool
// Steps the datapath through clearing pass, lookup, swap writes and response.
// ----------------------------------------------------------------------------
module eip_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  eip_pkg::t_dp_stat   i_stat,
    output logic                o_req_ready,
    output eip_pkg::t_dp_cmd    o_cmd
);
    import eip_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (i_stat.init_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req_valid) n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = i_stat.needs_swap ? S_SWAP : S_DONE;
            end
            S_SWAP: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.rsp_room) n_state = S_IDLE;
            end
            default: n_state = S_INIT;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_INIT: o_cmd.init = ~i_stat.init_done;
            S_IDLE: begin
                o_req_ready  = 1'b1;
                o_cmd.accept = i_req_valid;
            end
            S_EVAL: o_cmd.eval     = 1'b1;
            S_SWAP: o_cmd.swap2    = 1'b1;
            S_DONE: o_cmd.rsp_load = i_stat.rsp_room;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== sv/eip_dp.sv =====
// ----------------------------------------------------------------------------
// eip_dp: datapath of the entity ID pool
// Dense ID list and position map memories, allocated count, request and
// result registers and the output register.
// ----------------------------------------------------------------------------
module eip_dp #(
    parameter int NUM_IDS = eip_pkg::NUM_IDS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  eip_pkg::t_dp_cmd    i_cmd,
    input  eip_pkg::t_req       i_req_payload,
    input  logic                i_rsp_ready,
    output eip_pkg::t_dp_stat   o_stat,
    output logic                o_rsp_valid,
    output eip_pkg::t_rsp       o_rsp_payload
);
    import eip_pkg::*;

    localparam int AW = $clog2(NUM_IDS);
    localparam int CW = $clog2(NUM_IDS + 1);

    logic [AW-1:0] r_list_mem [NUM_IDS];
    logic [AW-1:0] r_slot_mem [NUM_IDS];
    logic [AW-1:0] r_list_q;
    logic [AW-1:0] r_slot_q;

    logic [AW-1:0] r_init_idx;
    logic          r_init_done;
    logic [CW-1:0] r_count;
    t_req          r_req;
    t_status       r_res_status;
    logic [GIVEN_W-1:0] r_res_given;
    logic          r_rsp_valid;
    t_rsp          r_rsp;

    logic [CW-1:0] w_count_m1;
    logic [AW-1:0] w_list_ra;
    logic [AW-1:0] w_req_idx;
    logic          w_exhausted;
    logic          w_invalid;
    logic          w_already;
    logic          w_needs_swap;
    t_status       w_status;

    logic          w_list_we;
    logic [AW-1:0] w_list_wa;
    logic [AW-1:0] w_list_wd;
    logic          w_slot_we;
    logic [AW-1:0] w_slot_wa;
    logic [AW-1:0] w_slot_wd;

    assign w_count_m1 = r_count - CW'(1);
    assign w_list_ra  = (i_req_payload.command == CMD_ALLOC) ? r_count[AW-1:0]
                                                             : w_count_m1[AW-1:0];
    assign w_req_idx  = r_req.entity_id[AW-1:0];

    assign w_exhausted  = (r_count == CW'(NUM_IDS));
    assign w_invalid    = ({1'b0, r_req.entity_id} >= (ID_W + 1)'(NUM_IDS));
    assign w_already    = (CW'(r_slot_q) >= r_count);
    assign w_needs_swap = (r_req.command == CMD_FREE) && !w_invalid && !w_already;

    always_comb begin
        if (r_req.command == CMD_ALLOC) begin
            w_status = w_exhausted ? ST_NONE : ST_OK;
        end else if (w_invalid) begin
            w_status = ST_INVALID;
        end else if (w_already) begin
            w_status = ST_ALREADY_FREE;
        end else begin
            w_status = ST_OK;
        end
    end

    // first swap: last allocated ID takes the freed ID's slot;
    // second swap: freed ID moves to the boundary slot
    always_comb begin
        w_list_we = 1'b0;
        w_list_wa = r_init_idx;
        w_list_wd = r_init_idx;
        w_slot_we = 1'b0;
        w_slot_wa = r_init_idx;
        w_slot_wd = r_init_idx;
        if (i_cmd.init) begin
            w_list_we = 1'b1;
            w_slot_we = 1'b1;
        end else if (i_cmd.eval && w_needs_swap) begin
            w_list_we = 1'b1;
            w_list_wa = r_slot_q;
            w_list_wd = r_list_q;
            w_slot_we = 1'b1;
            w_slot_wa = r_list_q;
            w_slot_wd = r_slot_q;
        end else if (i_cmd.swap2) begin
            w_list_we = 1'b1;
            w_list_wa = r_count[AW-1:0];
            w_list_wd = w_req_idx;
            w_slot_we = 1'b1;
            w_slot_wa = w_req_idx;
            w_slot_wd = r_count[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_list_we) r_list_mem[w_list_wa] <= w_list_wd;
        if (i_cmd.accept) r_list_q <= r_list_mem[w_list_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_slot_we) r_slot_mem[w_slot_wa] <= w_slot_wd;
        if (i_cmd.accept) r_slot_q <= r_slot_mem[i_req_payload.entity_id[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_idx  <= '0;
            r_init_done <= 1'b0;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_cmd.init) begin
                r_init_idx <= r_init_idx + AW'(1);
                if (r_init_idx == AW'(NUM_IDS - 1)) r_init_done <= 1'b1;
            end
            if (i_cmd.eval) begin
                if (r_req.command == CMD_ALLOC && !w_exhausted) begin
                    r_count <= r_count + CW'(1);
                end else if (w_needs_swap) begin
                    r_count <= w_count_m1;
                end
            end
            if (i_cmd.rsp_load) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_req <= i_req_payload;
        if (i_cmd.eval) begin
            r_res_status <= w_status;
            r_res_given  <= (r_req.command == CMD_ALLOC && !w_exhausted)
                            ? GIVEN_W'(r_list_q) : '0;
        end
        if (i_cmd.rsp_load) begin
            r_rsp.status   <= r_res_status;
            r_rsp.given_id <= r_res_given;
        end
    end

    assign o_stat.init_done  = r_init_done;
    assign o_stat.needs_swap = w_needs_swap;
    assign o_stat.rsp_room   = !r_rsp_valid || i_rsp_ready;
    assign o_rsp_valid       = r_rsp_valid;
    assign o_rsp_payload     = r_rsp;

endmodule

// ===== sv/entity_id_pool_unit.sv =====
// ----------------------------------------------------------------------------
// entity_id_pool_unit: entity ID allocator kept as a sparse set
// Top level: request and response channels, controller and datapath.
// ----------------------------------------------------------------------------
// Hands out and takes back IDs 0..NUM_IDS-1. Each request transaction on i_req
// (allocate, or free a given ID) yields exactly one response transaction on
// o_rsp with a status and, on a successful allocate, the ID. After reset the
// block runs a clearing pass in S_INIT that loads both maps, and
// takes its first request in S_IDLE once the pass has ended. One request is
// worked at a time: an allocate or any rejected request goes from S_IDLE
// through S_EVAL to S_DONE, which loads the response register once there is
// room; a successful free passes through S_SWAP on the way, since each map has
// one write port and a free writes each map twice. The next request is taken
// in S_IDLE after the load. A response that is not taken holds the next
// request's result back, while the next request is still accepted.
// ----------------------------------------------------------------------------
module entity_id_pool_unit #(
    parameter int NUM_IDS = eip_pkg::NUM_IDS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    eip_req_if.sink   i_req,
    eip_rsp_if.source o_rsp
);
    import eip_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    eip_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_stat      (w_stat),
        .o_req_ready (i_req.ready),
        .o_cmd       (w_cmd)
    );

    eip_dp #(
        .NUM_IDS (NUM_IDS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_req_payload (i_req.payload),
        .i_rsp_ready   (o_rsp.ready),
        .o_stat        (w_stat),
        .o_rsp_valid   (o_rsp.valid),
        .o_rsp_payload (o_rsp.payload)
    );

endmodule

// ===== tb/entity_id_pool_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// entity_id_pool_unit_tb: self-checking testbench of the entity ID pool
// Drives allocate and free requests with random gaps and checks every
// response against a sparse-set model of the pool. The stimulus fills the
// pool to exhaustion, drains it back to empty and churns in between, and it
// mixes in out-of-range and double frees. The response side stalls at
// random and twice holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module entity_id_pool_unit_tb;
    import eip_pkg::*;

    localparam int NUM_IDS      = NUM_IDS_DEF;
    localparam int ITEMS        = 1150;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 20;

    // two copies of the pool: one advanced while planning, one on acceptance
    localparam int PLAN_VIEW = 0;
    localparam int DUT_VIEW  = 1;

    localparam int PH_FILL  = 0;
    localparam int PH_DRAIN = 1;
    localparam int PH_CHURN = 2;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    eip_req_if req_ch ();
    eip_rsp_if rsp_ch ();

    logic drv_valid   = 1'b0;
    t_req drv_payload = '0;
    logic sink_ready  = 1'b0;

    assign req_ch.valid   = drv_valid;
    assign req_ch.payload = drv_payload;
    assign rsp_ch.ready   = sink_ready;

    entity_id_pool_unit #(
        .NUM_IDS(NUM_IDS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    // sparse-set pool model
    logic [7:0] dense_ids [2][NUM_IDS];
    logic [7:0] id_slot   [2][NUM_IDS];
    logic [8:0] live_count[2];

    t_req pending_reqs[$];
    t_rsp expected_rsp[$];

    int planned      = 0;
    int req_accepted = 0;
    int rsp_seen     = 0;
    int errors       = 0;
    int status_seen[4];
    int gap_left     = 0;
    int stall_left   = 0;
    int hold_left    = 0;
    int holds_done   = 0;
    int idle_cycles  = 0;

    function automatic t_rsp pool_apply(input int k, input t_req r);
        t_rsp       res;
        logic [7:0] pos;
        logic [7:0] last;
        res.status   = ST_OK;
        res.given_id = '0;
        if (r.command == CMD_ALLOC) begin
            if (live_count[k] >= NUM_IDS) begin
                res.status = ST_NONE;
            end else begin
                res.given_id  = dense_ids[k][live_count[k][7:0]];
                live_count[k] = live_count[k] + 1'b1;
            end
        end else if (r.entity_id >= NUM_IDS) begin
            res.status = ST_INVALID;
        end else begin
            pos = id_slot[k][r.entity_id[7:0]];
            if (pos >= live_count[k]) begin
                res.status = ST_ALREADY_FREE;
            end else begin
                // shrink the live count, then swap the freed ID with the last live one
                live_count[k]                    = live_count[k] - 1'b1;
                last                             = dense_ids[k][live_count[k][7:0]];
                dense_ids[k][pos]                = last;
                id_slot[k][last]                 = pos;
                dense_ids[k][live_count[k][7:0]] = r.entity_id[7:0];
                id_slot[k][r.entity_id[7:0]]     = live_count[k][7:0];
            end
        end
        return res;
    endfunction

    task automatic push_item(input t_cmd c, input logic [ID_W-1:0] id);
        t_req r;
        r.command   = c;
        r.entity_id = id;
        void'(pool_apply(PLAN_VIEW, r));
        pending_reqs.push_back(r);
        planned++;
    endtask

    task automatic push_noise();
        case ($urandom_range(0, 3))
            0: push_item(CMD_FREE, ID_W'($urandom_range(0, 65535)));
            1: push_item(CMD_FREE, ID_W'($urandom_range(NUM_IDS, 2 * NUM_IDS - 1)));
            2: begin
                if (live_count[PLAN_VIEW] < NUM_IDS)
                    push_item(CMD_FREE, ID_W'(dense_ids[PLAN_VIEW][
                        8'($urandom_range(live_count[PLAN_VIEW], NUM_IDS - 1))]));
                else
                    push_item(CMD_FREE, ID_W'($urandom_range(0, 65535)));
            end
            default: push_item(CMD_ALLOC, ID_W'($urandom_range(0, 65535)));
        endcase
    endtask

    task automatic push_live_free();
        if (live_count[PLAN_VIEW] == 0)
            push_noise();
        else
            push_item(CMD_FREE, ID_W'(dense_ids[PLAN_VIEW][
                8'($urandom_range(0, live_count[PLAN_VIEW] - 1))]));
    endtask

    task automatic run_phase(input int kind);
        int n;
        int r;
        case (kind)
            PH_FILL: begin
                while (live_count[PLAN_VIEW] < NUM_IDS) begin
                    if ($urandom_range(0, 9) == 0)
                        push_noise();
                    else
                        push_item(CMD_ALLOC, ID_W'($urandom_range(0, 65535)));
                end
                // push past the top to hit exhaustion
                repeat ($urandom_range(1, 4))
                    push_item(CMD_ALLOC, ID_W'($urandom_range(0, 65535)));
            end
            PH_DRAIN: begin
                while (live_count[PLAN_VIEW] > 0) begin
                    if ($urandom_range(0, 9) == 0)
                        push_noise();
                    else
                        push_live_free();
                end
                repeat ($urandom_range(1, 3))
                    push_item(CMD_FREE, ID_W'($urandom_range(0, NUM_IDS - 1)));
            end
            default: begin
                n = $urandom_range(30, 120);
                repeat (n) begin
                    r = $urandom_range(0, 99);
                    if (r < 45)
                        push_item(CMD_ALLOC, ID_W'($urandom_range(0, 65535)));
                    else if (r < 85)
                        push_live_free();
                    else
                        push_noise();
                end
            end
        endcase
    endtask

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        // leave every third stretch of 64 transactions back to back
        if ((req_accepted / 64) % 3 == 1)
            return 0;
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH @ %0t ns: %s", $time, what);
        errors++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // driver: request side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
            gap_left  <= 0;
        end else if (!drv_valid || req_ch.ready) begin
            if (gap_left > 0) begin
                gap_left  <= gap_left - 1;
                drv_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                drv_valid   <= 1'b1;
                drv_payload <= pending_reqs.pop_front();
                gap_left    <= draw_gap();
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // long hold-off of the response side, twice per run
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_done < 2 && req_accepted >= 250 + holds_done * 500) begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // response ready with random stalls
    always @(posedge i_clk) begin : sink_ctl
        int s;
        if (!i_rst_n) begin
            sink_ready <= 1'b0;
            stall_left <= 0;
        end else if (hold_left > 0) begin
            sink_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            sink_ready <= 1'b0;
        end else if (rsp_ch.valid && sink_ready) begin
            s = draw_gap();
            if (s > 0) begin
                sink_ready <= 1'b0;
                stall_left <= s - 1;
            end else begin
                sink_ready <= 1'b1;
            end
        end else begin
            sink_ready <= 1'b1;
        end
    end

    // monitor: predict on request transactions, check response transactions
    always @(posedge i_clk) begin : monitor
        t_rsp want;
        t_rsp got;
        if (i_rst_n) begin
            if (drv_valid && req_ch.ready) begin
                expected_rsp.push_back(pool_apply(DUT_VIEW, drv_payload));
                req_accepted <= req_accepted + 1;
            end
            if (rsp_ch.valid && sink_ready) begin
                got = rsp_ch.payload;
                rsp_seen++;
                if (!$isunknown(got.status))
                    status_seen[got.status]++;
                if (expected_rsp.size() == 0) begin
                    report_mismatch("response with no request outstanding");
                end else begin
                    want = expected_rsp.pop_front();
                    if (got.status !== want.status)
                        report_mismatch($sformatf("response %0d: status %0d, expected %s",
                            rsp_seen, got.status, want.status.name()));
                    if (got.given_id !== want.given_id)
                        report_mismatch($sformatf("response %0d: given_id %0d, expected %0d",
                            rsp_seen, got.given_id, want.given_id));
                end
            end
        end
    end

    // watchdog: cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((drv_valid && req_ch.ready) || (rsp_ch.valid && sink_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("entity_id_pool_unit regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        for (int k = 0; k < 2; k++) begin
            for (int i = 0; i < NUM_IDS; i++) begin
                dense_ids[k][i] = i[7:0];
                id_slot[k][i]   = i[7:0];
            end
            live_count[k] = '0;
        end
        for (int i = 0; i < 4; i++) status_seen[i] = 0;

        // directed: frees on an empty pool, range edges, swaps in the middle,
        // at the end and at the front of the live slots
        push_item(CMD_FREE, 16'd0);
        push_item(CMD_FREE, 16'd255);
        push_item(CMD_FREE, 16'd256);
        push_item(CMD_FREE, 16'hFFFF);
        push_item(CMD_FREE, 16'h8000);
        push_item(CMD_ALLOC, 16'hFFFF);
        push_item(CMD_ALLOC, 16'h0000);
        push_item(CMD_ALLOC, 16'hAAAA);
        push_item(CMD_ALLOC, 16'h5555);
        push_item(CMD_FREE, 16'd1);
        push_item(CMD_FREE, 16'd2);
        push_item(CMD_FREE, 16'd1);
        push_item(CMD_ALLOC, 16'h00FF);
        push_item(CMD_ALLOC, 16'h7FFF);
        push_item(CMD_FREE, 16'd0);
        push_item(CMD_FREE, 16'd0);
        push_item(CMD_ALLOC, 16'h0100);
        push_item(CMD_FREE, 16'd255);
        push_item(CMD_FREE, 16'd257);
        push_item(CMD_FREE, 16'd3);

        // random: one full sweep each way first, then mixed phases
        run_phase(PH_FILL);
        run_phase(PH_DRAIN);
        while (planned < ITEMS) run_phase($urandom_range(PH_FILL, PH_CHURN));
        // drop the overshoot of the last phase; the acceptance-side model
        // only ever sees what is sent
        while (pending_reqs.size() > ITEMS) void'(pending_reqs.pop_back());

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || drv_valid || expected_rsp.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests and %0d responses, %0d long response hold-offs",
            req_accepted, rsp_seen, holds_done);
        $display("statuses seen: ok %0d, none available %0d, invalid %0d, already free %0d",
            status_seen[ST_OK], status_seen[ST_NONE], status_seen[ST_INVALID],
            status_seen[ST_ALREADY_FREE]);
        if (errors == 0) begin
            $display("entity_id_pool_unit regression: pass");
        end else begin
            $display("%0d mismatches", errors);
            $display("entity_id_pool_unit regression: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/eip_pkg.sv
sv/eip_if.sv
sv/eip_ctrl.sv
sv/eip_dp.sv
sv/entity_id_pool_unit.sv
tb/entity_id_pool_unit_tb.sv
